// ----- rtl/core/cqs_pkg.sv -----
// Shared constants and codes for the circular queue with search.
package cqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RS_W     = 5;
    localparam int ADDR_W   = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // register index (byte address bit 2)
    localparam logic REG_RING_SIZE = 1'b0;

    localparam logic [RS_W-1:0] RING_SIZE_RST = 5'd16;

endpackage

// ----- rtl/core/cqs_ring_mem.sv -----
// Ring storage: single write port, registered read port, zeroing sweep after reset.
module cqs_ring_mem #(
    parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = cqs_pkg::WORD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_WIDTH-1:0]    wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_WIDTH-1:0]    rd_data,
    output logic                     clr_busy
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  clr_busy_reg;
    logic [PTR_W-1:0]      clr_idx_reg;

    // zero one slot per cycle until the whole store is clean
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + PTR_W'(1);
            if (clr_idx_reg == PTR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ----- rtl/core/circular_queue_with_search_unit.sv -----
// Top level: ring queue of signed words with push, pop and full-ring key search.
//
// Input channel (s_*): one item per command; s_tuser carries the command
// (push, pop, search), s_tdata the value or search key.
// Result channel (m_*): exactly one result item per input item, holding the
// popped word, the word at the read pointer, found, empty and status.
// APB port: register 0 (byte address 0) is ring_size, the number of active
// slots; write it only while the block is idle.
// Sequence per item: push goes through S_PUSH, S_FRONT and S_DONE; pop
// through S_POP, S_POP_DATA (skipped on an empty ring), S_FRONT and S_DONE;
// an unused command through S_FRONT and S_DONE; a search steps S_SRCH over
// L slots, where L is ring_size held to 1..DEPTH, then S_FRONT and S_DONE.
// One item is in flight at a time: s_tready is low until the sequencer is back
// in idle. The one shared comparator is stepped one slot per cycle in a search.
// A finished result sits in an output register; the next item is accepted
// while it waits; the sequencer holds its next result until the register is free.
// Reset clears pointers and occupancy and sets ring_size to 16; the store
// is then zeroed one slot per cycle, and s_tready stays low until it is clean.
module circular_queue_with_search_unit #(
    parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = cqs_pkg::WORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] value
    input  logic [1:0]                  s_tuser,   // [1:0] command
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [31:0] popped_value, [63:32] front_value, [64] found, [65] is_empty,
    // [67:66] status, [71:68] zero
    output logic [71:0]                 m_tdata,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cqs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int LW    = (CNT_W > cqs_pkg::RS_W) ? CNT_W : cqs_pkg::RS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUSH     = 3'd1;
    localparam logic [2:0] S_POP      = 3'd2;
    localparam logic [2:0] S_POP_DATA = 3'd3;
    localparam logic [2:0] S_SRCH     = 3'd4;
    localparam logic [2:0] S_FRONT    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]                     state_reg, state_next;
    logic [cqs_pkg::RS_W-1:0]       ring_size_reg;
    logic [PTR_W-1:0]               wp_reg, rp_reg, idx_reg;
    logic [CNT_W-1:0]               occ_reg;
    logic [cqs_pkg::CMD_W-1:0]      cmd_reg;
    logic [WORD_WIDTH-1:0]          key_reg;
    logic [WORD_WIDTH-1:0]          popped_reg;
    logic [cqs_pkg::STATUS_W-1:0]   status_reg;
    logic                           found_reg;
    logic                           cmp_pend_reg;
    logic                           m_tvalid_reg;
    logic [71:0]                    m_tdata_reg;

    logic                           s_fire, out_free, cfg_we;
    logic [LW-1:0]                  rs_w;
    logic [CNT_W-1:0]               len;
    logic                           full;
    logic [63:0]                    value_ext;
    logic [WORD_WIDTH-1:0]          rd_data;
    logic [PTR_W-1:0]               rd_addr;
    logic                           mem_we;
    logic                           clr_busy;
    logic [63:0]                    front_ext, popped_ext;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] nx;
        nx = {1'b0, p} + CNT_W'(1);
        advance = (nx >= n) ? '0 : nx[PTR_W-1:0];
    endfunction

    // active ring length: zero counts as one, saturate at DEPTH
    always_comb begin
        rs_w = LW'(ring_size_reg);
        if (rs_w == '0) begin
            rs_w = LW'(1);
        end else if (rs_w > LW'(DEPTH)) begin
            rs_w = LW'(DEPTH);
        end
        len = rs_w[CNT_W-1:0];
    end

    assign full      = (occ_reg >= len);
    assign value_ext = {{32{s_tdata[31]}}, s_tdata};
    assign s_tready  = (state_reg == S_IDLE) && !clr_busy;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign rd_addr   = (state_reg == S_SRCH) ? idx_reg : rp_reg;
    assign mem_we    = (state_reg == S_PUSH) && !full;

    cqs_ring_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_we),
        .wr_addr  (wp_reg),
        .wr_data  (key_reg),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == cqs_pkg::REG_RING_SIZE) ? 32'(ring_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= cqs_pkg::RING_SIZE_RST;
        end else if (cfg_we && (paddr[2] == cqs_pkg::REG_RING_SIZE)) begin
            ring_size_reg <= pwdata[cqs_pkg::RS_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    priority case (s_tuser)
                        cqs_pkg::CMD_PUSH:   state_next = S_PUSH;
                        cqs_pkg::CMD_POP:    state_next = S_POP;
                        cqs_pkg::CMD_SEARCH: state_next = S_SRCH;
                        default:             state_next = S_FRONT;
                    endcase
                end
            end
            S_PUSH:     state_next = S_FRONT;
            S_POP:      state_next = (occ_reg == '0) ? S_FRONT : S_POP_DATA;
            S_POP_DATA: state_next = S_FRONT;
            S_SRCH: begin
                if (({1'b0, idx_reg} + CNT_W'(1)) >= len) begin
                    state_next = S_FRONT;
                end
            end
            S_FRONT:    state_next = S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            occ_reg      <= '0;
            idx_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            found_reg    <= 1'b0;
            status_reg   <= cqs_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_pend_reg <= (state_reg == S_SRCH);
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // shared comparator: one slot per cycle, checked in the cycle after its read address
            if (cmp_pend_reg && (rd_data == key_reg)) begin
                found_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        found_reg  <= 1'b0;
                        status_reg <= cqs_pkg::ST_OK;
                        idx_reg    <= '0;
                    end
                end
                S_PUSH: begin
                    if (full) begin
                        status_reg <= cqs_pkg::ST_FULL;
                    end else begin
                        wp_reg  <= advance(wp_reg, len);
                        occ_reg <= occ_reg + CNT_W'(1);
                    end
                end
                S_POP: begin
                    if (occ_reg == '0) begin
                        status_reg <= cqs_pkg::ST_EMPTY;
                    end
                end
                S_POP_DATA: begin
                    rp_reg  <= advance(rp_reg, len);
                    occ_reg <= occ_reg - CNT_W'(1);
                end
                S_SRCH: begin
                    idx_reg <= idx_reg + PTR_W'(1);
                end
                S_FRONT: ;
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    assign front_ext  = 64'(rd_data);
    assign popped_ext = 64'(popped_reg);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg    <= s_tuser;
            key_reg    <= value_ext[WORD_WIDTH-1:0];
            popped_reg <= '0;
        end else if (state_reg == S_POP_DATA) begin
            popped_reg <= rd_data;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_tdata_reg <= {4'b0000, status_reg, (occ_reg == '0),
                            found_reg && (cmd_reg == cqs_pkg::CMD_SEARCH),
                            front_ext[31:0], popped_ext[31:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg <= PTR_W'(DEPTH - 1)) && (rp_reg <= PTR_W'(DEPTH - 1)))
        else $error("pointer beyond store");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH) && !full |=> occ_reg == $past(occ_reg) + CNT_W'(1))
        else $error("push did not grow occupancy");
`endif

endmodule

// ----- sim/testbench.sv -----
// Testbench for the circular queue with search: directed and random command streams.
`timescale 1ns / 100ps

module testbench;

    localparam int                         RING_DEPTH     = cqs_pkg::DEPTH_DEF;
    localparam logic [cqs_pkg::CMD_W-1:0]  CMD_NOP        = 2'd3;   // unused code, no operation
    localparam int                         STALL_PCT      = 28;
    localparam int                         WATCHDOG_LIMIT = 2000;
    localparam int                         RANDOM_PHASES  = 16;
    localparam int                         PHASE_ITEMS    = 100;

    typedef struct {
        logic [31:0]                  popped;
        logic [31:0]                  front;
        logic                         found;
        logic                         empty;
        logic [cqs_pkg::STATUS_W-1:0] status;
    } ring_result_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata  = '0;
    logic [cqs_pkg::CMD_W-1:0]    s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [71:0]                  m_tdata;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [cqs_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [31:0]                  pwdata   = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    logic                         idle_en  = 1'b1;
    int                           errors   = 0;
    int                           quiet_cycles = 0;
    ring_result_t                 expected_results[$];

    // shadow of the ring
    logic [31:0]                  ring_mem [RING_DEPTH];
    int unsigned                  wr_ptr;
    int unsigned                  rd_ptr;
    int unsigned                  fill;
    logic [cqs_pkg::RS_W-1:0]     ring_size_reg;

    circular_queue_with_search_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // size 0 acts as one slot, sizes above the depth saturate
    function automatic int unsigned active_len();
        int unsigned n;
        n = ring_size_reg;
        if (n == 0)
            n = 1;
        if (n > RING_DEPTH)
            n = RING_DEPTH;
        return n;
    endfunction

    function automatic int unsigned next_slot(int unsigned p, int unsigned len);
        return (p + 1 >= len) ? 0 : p + 1;
    endfunction

    function automatic ring_result_t queue_step(logic [cqs_pkg::CMD_W-1:0] cmd,
                                                logic [31:0] val);
        ring_result_t r;
        int unsigned  len;
        len = active_len();
        r.popped = '0;
        r.found  = 1'b0;
        r.status = cqs_pkg::ST_OK;
        case (cmd)
            cqs_pkg::CMD_PUSH: begin
                if (fill >= len) begin
                    r.status = cqs_pkg::ST_FULL;
                end else begin
                    ring_mem[wr_ptr] = val;
                    wr_ptr = next_slot(wr_ptr, len);
                    fill++;
                end
            end
            cqs_pkg::CMD_POP: begin
                if (fill == 0) begin
                    r.status = cqs_pkg::ST_EMPTY;
                end else begin
                    r.popped = ring_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr, len);
                    fill--;
                end
            end
            cqs_pkg::CMD_SEARCH: begin
                // stale slots take part as well
                for (int i = 0; i < len; i++)
                    if (ring_mem[i] == val)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.front = ring_mem[rd_ptr];
        r.empty = (fill == 0);
        return r;
    endfunction

    task automatic send_item(input logic [cqs_pkg::CMD_W-1:0] cmd, input logic [31:0] val);
        if (idle_en && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(queue_step(cmd, val));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // APB write, then read back
    task automatic write_ring_size(input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cqs_pkg::REG_RING_SIZE, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        ring_size_reg = val[cqs_pkg::RS_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== 32'(ring_size_reg)) begin
            $display("%0t ring_size readback: expected %h actual %h",
                     $time, 32'(ring_size_reg), prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t %s: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        ring_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("popped_value", want.popped, m_tdata[31:0]);
                check_field("front_value", want.front, m_tdata[63:32]);
                check_field("found", 32'(want.found), 32'(m_tdata[64]));
                check_field("is_empty", 32'(want.empty), 32'(m_tdata[65]));
                check_field("status", 32'(want.status), 32'(m_tdata[67:66]));
                check_field("pad", 32'd0, 32'(m_tdata[71:68]));
            end
        end
    end

    always @(posedge aclk)
        m_tready <= !idle_en || ($urandom_range(99) >= STALL_PCT);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_empty_ring();
        send_item(cqs_pkg::CMD_POP, 32'h0);
        send_item(cqs_pkg::CMD_SEARCH, 32'h0);          // cleared store matches zero
        send_item(cqs_pkg::CMD_SEARCH, 32'h8000_0000);
        send_item(CMD_NOP, 32'hFFFF_FFFF);
    endtask

    task automatic test_value_extremes();
        send_item(cqs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_item(cqs_pkg::CMD_PUSH, 32'h8000_0000);
        send_item(cqs_pkg::CMD_SEARCH, 32'h8000_0000);
        send_item(cqs_pkg::CMD_POP, 32'h0);
        send_item(cqs_pkg::CMD_POP, 32'h0);
        send_item(cqs_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_single_slot();
        drain_results();
        write_ring_size(32'd1);
        send_item(cqs_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        send_item(cqs_pkg::CMD_PUSH, 32'h0000_0001);    // full
        send_item(cqs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        send_item(cqs_pkg::CMD_POP, 32'h0);
        drain_results();
        write_ring_size(32'd0);                         // acts as one slot
        send_item(cqs_pkg::CMD_PUSH, 32'h5A5A_5A5A);
        send_item(cqs_pkg::CMD_PUSH, 32'hA5A5_A5A5);
        send_item(cqs_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_oversize_ring();
        drain_results();
        write_ring_size(32'd31);                        // saturates to the depth
        send_item(cqs_pkg::CMD_PUSH, 32'h1234_5678);
        send_item(cqs_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_resize_in_use();
        drain_results();
        write_ring_size(32'd16);
        repeat (3) send_item(cqs_pkg::CMD_PUSH, $urandom());
        drain_results();
        write_ring_size(32'd2);                         // occupancy now above the length
        send_item(cqs_pkg::CMD_PUSH, 32'hDEAD_BEEF);
        send_item(cqs_pkg::CMD_SEARCH, 32'h1234_5678);
        repeat (3) send_item(cqs_pkg::CMD_POP, 32'h0);
    endtask

    task automatic test_random_traffic();
        logic [31:0]               pool [8];
        logic [cqs_pkg::CMD_W-1:0] cmd;
        logic [31:0]               val;
        int unsigned               push_pct;
        int unsigned               pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            pick = $urandom_range(9);
            if (phase == 0)
                write_ring_size(32'd16);
            else if (phase == 1)
                write_ring_size(32'd1);
            else if (pick == 0)
                write_ring_size(32'd0);
            else if (pick == 1)
                write_ring_size($urandom_range(17, 31));
            else if (pick < 6)
                write_ring_size($urandom_range(1, 4));
            else
                write_ring_size($urandom_range(5, 16));
            // a long stretch with both sides always ready
            idle_en = !(phase == 5 || phase == 6);
            push_pct = (phase % 3 == 0) ? 35 : (phase % 3 == 1) ? 50 : 65;
            foreach (pool[i])
                pool[i] = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < push_pct) begin
                    cmd = cqs_pkg::CMD_PUSH;
                end else begin
                    pick = $urandom_range(99);
                    cmd = (pick < 60) ? cqs_pkg::CMD_POP :
                          (pick < 95) ? cqs_pkg::CMD_SEARCH : CMD_NOP;
                end
                pick = $urandom_range(9);
                if (pick < 5)
                    val = pool[$urandom_range(7)];
                else if (pick < 8)
                    val = $urandom();
                else if (pick == 8)
                    val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                else
                    val = $urandom_range(3);
                send_item(cmd, val);
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
        ring_size_reg = cqs_pkg::RING_SIZE_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_ring();
        test_value_extremes();
        test_single_slot();
        test_oversize_ring();
        test_resize_in_use();
        test_random_traffic();

        drain_results();
        repeat (RING_DEPTH + 8) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cqs_pkg.sv
rtl/core/cqs_ring_mem.sv
rtl/core/circular_queue_with_search_unit.sv
sim/testbench.sv
